// ===== hw/rtl/grid_ray_dda_cast_macros.svh =====
// Assertion macros used by the ray caster controller.
`ifndef GRID_RAY_DDA_CAST_MACROS_SVH
`define GRID_RAY_DDA_CAST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GRDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grdc assertion failed");

// Next-cycle implication, checked outside reset.
`define GRDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grdc assertion failed");

`endif

// ===== hw/rtl/grdc_pkg.sv =====
// Shared types, constants and helpers for the grid ray caster.
package grdc_pkg;

  localparam int MAP_W        = 32;
  localparam int MAP_H        = 32;
  localparam int TEX_SIZE     = 32;
  localparam int MAP_DEPTH    = MAP_W * MAP_H;
  localparam int MAP_AW       = $clog2(MAP_DEPTH);
  localparam int CLR_W        = $clog2(MAP_DEPTH + 1);
  localparam int CW           = 12;
  localparam logic [15:0] MAX_DIST_RST = 16'd1280;

  typedef struct packed {
    logic              mode;
    logic [4:0]        tile_x;
    logic [4:0]        tile_y;
    logic              tile_solid;
    logic [15:0]       start_x;
    logic [15:0]       start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        side;
    logic [15:0] hit_distance;
    logic [4:0]  hit_tile_x;
    logic [4:0]  hit_tile_y;
    logic [4:0]  texture_column;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic div_go;
    logic div_y;
    logic init_x;
    logic init_y;
    logic step;
    logic hit_mul;
    logic emit_hit;
    logic emit_miss;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic limit;
    logic solid;
    logic in_range;
  } dp_status_t;

  function automatic logic [MAP_AW-1:0] map_addr(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y);
    return MAP_AW'(32'(y) * MAP_W + 32'(x));
  endfunction

endpackage

// ===== hw/rtl/grdc_recip.sv =====
// Iterative reciprocal unit: floor(2^22 / a), saturated to 16 bits, one bit per cycle.
module grdc_recip import grdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] q_r, q_nxt;
  logic [15:0] a_r, a_nxt;
  logic        sat_r, sat_nxt;
  logic [16:0] trial;

  // With a above 64 the quotient fits 16 bits, so the top of 2^22 (64) is the first remainder.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    a_nxt    = a_r;
    sat_nxt  = sat_r;
    trial    = {rem_r, 1'b0};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = 4'd0;
      rem_nxt = 16'd64;
      q_nxt   = 16'd0;
      a_nxt   = divisor;
      sat_nxt = (divisor <= 16'd64);
    end else if (run_r) begin
      if (trial >= {1'b0, a_r}) begin
        rem_nxt = 16'(trial - {1'b0, a_r});
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    a_r   <= a_nxt;
    sat_r <= sat_nxt;
  end

  assign done     = done_r;
  assign quotient = sat_r ? 16'hFFFF : q_r;

endmodule

// ===== hw/rtl/grdc_ctrl.sv =====
// Controller state machine for the grid ray caster.
`include "grid_ray_dda_cast_macros.svh"
module grdc_ctrl import grdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       mode,
  input  dp_status_t st,
  output dp_cmd_t    cmd,
  output logic       busy
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_XGO   = 4'd2;
  localparam logic [3:0] S_DIVX  = 4'd3;
  localparam logic [3:0] S_YGO   = 4'd4;
  localparam logic [3:0] S_DIVY  = 4'd5;
  localparam logic [3:0] S_INITX = 4'd6;
  localparam logic [3:0] S_INITY = 4'd7;
  localparam logic [3:0] S_STEP  = 4'd8;
  localparam logic [3:0] S_READ  = 4'd9;
  localparam logic [3:0] S_CHECK = 4'd10;
  localparam logic [3:0] S_HMUL  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        if (st.clear_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clear = 1'b1;
        end
      end
      S_IDLE: begin
        cmd.load = start;
        if (start && mode) begin
          state_nxt = S_XGO;
        end
      end
      S_XGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVX;
      end
      S_DIVX: begin
        if (st.div_done) begin
          state_nxt = S_YGO;
        end
      end
      S_YGO: begin
        cmd.div_go = 1'b1;
        cmd.div_y  = 1'b1;
        state_nxt  = S_DIVY;
      end
      S_DIVY: begin
        cmd.div_y = 1'b1;
        if (st.div_done) begin
          state_nxt = S_INITX;
        end
      end
      S_INITX: begin
        cmd.init_x = 1'b1;
        state_nxt  = S_INITY;
      end
      S_INITY: begin
        cmd.init_y = 1'b1;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        if (st.limit) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!st.solid) begin
          state_nxt = S_STEP;
        end else if (st.in_range) begin
          state_nxt = S_HMUL;
        end else begin
          cmd.emit_miss = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_HMUL: begin
        cmd.hit_mul = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        cmd.emit_hit = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // A result strobe lasts one cycle; the divider only finishes while it is awaited.
  `GRDC_ASSERT_NEXT(a_emit_single, cmd.emit_hit || cmd.emit_miss, !cmd.emit_hit && !cmd.emit_miss)
  `GRDC_ASSERT_NOW(a_div_awaited, st.div_done, state_r == S_DIVX || state_r == S_DIVY)
  `GRDC_ASSERT_NOW(a_idle_after_clear, state_r == S_IDLE, st.clear_done)

endmodule

// ===== hw/rtl/grdc_dp.sv =====
// Datapath for the grid ray caster: tile map, reciprocal unit, DDA walk and hit math.
module grdc_dp import grdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output dp_status_t  st,
  output logic        out_valid,
  output out_item_t   out_result
);

  logic map_mem [MAP_DEPTH];

  logic [CLR_W-1:0]   clr_r;
  logic [15:0]        max_r;
  logic [15:0]        sx_r, sy_r;
  logic signed [15:0] dx_r, dy_r;
  logic [15:0]        ux_r, uy_r;
  logic [17:0]        rx_r, ry_r, dist_r;
  logic [CW-1:0]      tx_r, ty_r;
  logic               side_r;
  logic [21:0]        prod_r;
  logic               rdata_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               wr_en, wr_data;
  logic [MAP_AW-1:0]  wr_addr;
  logic [15:0]        div_in, quo;
  logic               div_done;
  logic [11:0]        fx, fy;
  logic [27:0]        px, py;
  logic               adv_x;
  logic [CW-1:0]      stx, sty;
  logic signed [15:0] dsel;
  logic signed [33:0] hp;
  logic [15:0]        base;
  logic [21:0]        pos_lo;
  logic [31:0]        tex_full;
  logic               in_map;

  grdc_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .divisor  (div_in),
    .done     (div_done),
    .quotient (quo)
  );

  // Absolute value of the selected direction; the most negative code maps to 32768.
  always_comb begin
    dsel   = cmd.div_y ? dy_r : dx_r;
    div_in = dsel[15] ? 16'(~dsel + 16'sd1) : dsel;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = 1'b0;
    wr_addr = clr_r[MAP_AW-1:0];
    if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.load && !in_item.mode &&
                 (CW'(in_item.tile_x) < CW'(MAP_W)) && (CW'(in_item.tile_y) < CW'(MAP_H))) begin
      wr_en   = 1'b1;
      wr_data = in_item.tile_solid;
      wr_addr = map_addr(CW'(in_item.tile_x), CW'(in_item.tile_y));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rdata_r <= map_mem[map_addr(tx_r, ty_r)];
  end

  // The boundary fraction is measured toward the side the ray moves to.
  always_comb begin
    fx  = dx_r[15] ? {1'b0, sx_r[10:0]} : 12'(12'd2048 - {1'b0, sx_r[10:0]});
    fy  = dy_r[15] ? {1'b0, sy_r[10:0]} : 12'(12'd2048 - {1'b0, sy_r[10:0]});
    px  = 28'(fx) * 28'(ux_r);
    py  = 28'(fy) * 28'(uy_r);
    adv_x = rx_r < ry_r;
    stx = dx_r[15] ? {CW{1'b1}} : CW'(1);
    sty = dy_r[15] ? {CW{1'b1}} : CW'(1);
    hp  = 34'(side_r ? dx_r : dy_r) * 34'($signed({1'b0, dist_r[16:0]}));
    base     = side_r ? sx_r : sy_r;
    pos_lo   = 22'({base, 11'b0}) + prod_r;
    tex_full = 32'(pos_lo) * 32'(TEX_SIZE);
    in_map   = !tx_r[CW-1] && !ty_r[CW-1] &&
               (tx_r < CW'(MAP_W)) && (ty_r < CW'(MAP_H));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      max_r       <= MAX_DIST_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      out_valid_r <= cmd.emit_hit || cmd.emit_miss;
    end

    if (cmd.load) begin
      sx_r   <= in_item.start_x;
      sy_r   <= in_item.start_y;
      dx_r   <= in_item.dir_x;
      dy_r   <= in_item.dir_y;
      tx_r   <= CW'(in_item.start_x[15:11]);
      ty_r   <= CW'(in_item.start_y[15:11]);
      dist_r <= '0;
      side_r <= 1'b0;
    end
    if (div_done) begin
      if (cmd.div_y) begin
        uy_r <= quo;
      end else begin
        ux_r <= quo;
      end
    end
    if (cmd.init_x) begin
      rx_r <= 18'(px[27:11]);
    end
    if (cmd.init_y) begin
      ry_r <= 18'(py[27:11]);
    end
    if (cmd.step) begin
      if (adv_x) begin
        tx_r   <= tx_r + stx;
        dist_r <= rx_r;
        rx_r   <= rx_r + 18'(ux_r);
        side_r <= 1'b0;
      end else begin
        ty_r   <= ty_r + sty;
        dist_r <= ry_r;
        ry_r   <= ry_r + 18'(uy_r);
        side_r <= 1'b1;
      end
    end
    if (cmd.hit_mul) begin
      prod_r <= hp[21:0];
    end
    if (cmd.emit_hit) begin
      out_r.hit            <= 1'b1;
      out_r.side           <= side_r;
      out_r.hit_distance   <= dist_r[15:0];
      out_r.hit_tile_x     <= tx_r[4:0];
      out_r.hit_tile_y     <= ty_r[4:0];
      out_r.texture_column <= tex_full[26:22];
    end else if (cmd.emit_miss) begin
      out_r <= '0;
    end
  end

  always_comb begin
    st.clear_done = (clr_r == CLR_W'(MAP_DEPTH));
    st.div_done   = div_done;
    st.limit      = dist_r >= 18'(max_r);
    st.solid      = in_map && rdata_r;
    st.in_range   = dist_r < 18'(max_r);
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

// ===== hw/rtl/grid_ray_dda_cast.sv =====
// Top level of the grid ray caster: controller plus datapath.
//
//  channel | ports                    | handshake
//  --------+--------------------------+-------------------------------------------
//  input   | start, busy, in_item     | transaction when start is high, busy low
//  result  | out_valid, out_result    | one-cycle strobe, always taken
//  config  | cfg_we, cfg_wdata        | register written when cfg_we is high
//
// After reset the map is cleared one tile a cycle; busy stays high until every tile is cleared.
// A tile write gives no result.
// A cast runs setup (per axis one start state and a wait in the shared serial divider,
// then two boundary multiplies), then per boundary step the states step, map read and
// test, then the hit multiply and output for a hit; a miss is given at the distance
// limit or for a solid tile out of range. The result strobe follows in the next cycle.
// The result strobe may overlap the cycle in which the next transaction is accepted.
module grid_ray_dda_cast import grdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_result,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;

  grdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_item.mode),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  grdc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .st         (st),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule
